@@ rtl/core/fat12_cluster_chain_engine_top_assert.svh @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine assertion macros
// Property helpers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_ENGINE_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fat12cce_pkg.sv @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine package
// Shared types, codes and constants of the cluster chain engine.
// ----------------------------------------------------------------------------
package fat12cce_pkg;

    localparam int CLU_W       = 12;
    localparam int CNT_W       = 13;
    localparam int ENTRIES_DEF = 4096;
    localparam int Q_DEPTH_DEF = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;
    localparam logic [CLU_W-1:0] END_MARK  = 12'hFF8;
    localparam logic [CLU_W-1:0] FREE_MARK = 12'h000;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_LINK   = 2'd1,
        OP_ALLOC  = 2'd2,
        OP_LOAD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NOFREE  = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [CLU_W-1:0] cluster;
        logic [CLU_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [CLU_W-1:0] result_cluster;
    } t_rsp;

    // request as classified by the front part
    typedef struct packed {
        t_req req;
        logic oor;
    } t_cmd;

endpackage

@@ rtl/core/fat12_cluster_chain_engine_top.sv @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine
// FAT12 allocation table with lookup, guarded link, allocate and load.
// ----------------------------------------------------------------------------
// Requests enter through a queue port: drive i_req and push while full is low.
// Results leave through a queue port: o_rsp holds the oldest result while
// empty is low, pop takes it. Every request gives exactly one result, in order.
// The entry_count register is written on the cfg_valid/cfg_ready channel
// (ready is always high); write it only while no request is in flight.
// In the back end, load and out-of-range requests finish as they are taken;
// lookup and link read the table, then check and write back. Allocate first
// checks the parent (skipped without a parent), then scans for the first
// free entry below the limit, then links the parent and writes the end mark
// when an entry was found. The scan reads one entry per cycle through the
// table's single read port. A request passes through the request queue
// before the back end and through the result queue after it.
// When pop stays low the two-entry result queue fills, the back end holds,
// then the request queue fills and full rises.
// Reset empties both queues and sets entry_count to 4096; table entries stay
// undefined until loaded, and reading one before that gives arbitrary results.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_engine_top_assert.svh"

module fat12_cluster_chain_engine_top #(
    parameter int ENTRIES = fat12cce_pkg::ENTRIES_DEF,
    parameter int Q_DEPTH = fat12cce_pkg::Q_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  fat12cce_pkg::t_req              i_req,
    output logic                            empty,
    input  logic                            pop,
    output fat12cce_pkg::t_rsp              o_rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fat12cce_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int LW    = $clog2(ENTRIES) + 1;
    localparam int RSP_W = $bits(fat12cce_pkg::t_rsp);

    logic [fat12cce_pkg::CNT_W-1:0] r_entry_count;
    logic [LW-1:0]                  limit;
    logic                           cmd_valid;
    logic                           cmd_take;
    fat12cce_pkg::t_cmd             cmd;
    logic                           rsp_push;
    logic                           rsp_full;
    fat12cce_pkg::t_rsp             rsp;
    logic [RSP_W-1:0]               rsp_q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= fat12cce_pkg::CNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // active limit: the smaller of entry_count and the table size
    assign limit = (r_entry_count < fat12cce_pkg::CNT_W'(ENTRIES)) ?
                   LW'(r_entry_count) : LW'(ENTRIES);

    fat12cce_front #(
        .ENTRIES (ENTRIES),
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req       (i_req),
        .i_limit     (limit),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    fat12cce_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_limit     (limit),
        .i_rsp_full  (rsp_full),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp)
    );

    fat12cce_queue #(
        .WIDTH (RSP_W),
        .DEPTH (Q_DEPTH)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rsp_push),
        .o_full  (rsp_full),
        .i_wdata (rsp),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (rsp_q_data)
    );

    assign o_rsp = fat12cce_pkg::t_rsp'(rsp_q_data);

    `FCCE_ASSERT_NOW(a_rsp_push_room, rsp_push, !rsp_full,
        "result beat pushed into a full result queue")
    `FCCE_ASSERT_NOW(a_take_valid, cmd_take, cmd_valid,
        "back end took a command from an empty queue")
    `FCCE_ASSERT_NOW(a_range_zero,
        rsp_push && (rsp.status == fat12cce_pkg::ST_RANGE), rsp.result_cluster == '0,
        "out-of-range result carries a nonzero cluster")
    `FCCE_ASSERT_NEXT(a_take_holds_result_slot, cmd_take && !pop && rsp_full, rsp_full,
        "result queue drained without a pop")

endmodule

@@ rtl/core/fat12cce_queue.sv @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module fat12cce_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = fat12cce_pkg::Q_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_data[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/core/fat12cce_front.sv @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine front
// Accepts requests, flags out-of-range indexes and queues them for the back.
// ----------------------------------------------------------------------------
module fat12cce_front #(
    parameter int ENTRIES = fat12cce_pkg::ENTRIES_DEF,
    parameter int Q_DEPTH = fat12cce_pkg::Q_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  fat12cce_pkg::t_req         i_req,
    input  logic [$clog2(ENTRIES):0]   i_limit,
    output logic                       o_cmd_valid,
    output fat12cce_pkg::t_cmd         o_cmd,
    input  logic                       i_cmd_take
);

    localparam int CMD_W = $bits(fat12cce_pkg::t_cmd);

    fat12cce_pkg::t_cmd cmd_in;
    logic               no_parent;
    logic               q_empty;
    logic [CMD_W-1:0]   q_rdata;

    // allocate without a parent is never out of range
    assign no_parent  = (i_req.op == fat12cce_pkg::OP_ALLOC) && (i_req.cluster == '0);
    assign cmd_in.req = i_req;
    assign cmd_in.oor = !no_parent &&
        (fat12cce_pkg::CNT_W'(i_req.cluster) >= fat12cce_pkg::CNT_W'(i_limit));

    fat12cce_queue #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .o_full  (o_full),
        .i_wdata (cmd_in),
        .i_rd    (i_cmd_take),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign o_cmd_valid = !q_empty;
    assign o_cmd       = fat12cce_pkg::t_cmd'(q_rdata);

endmodule

@@ rtl/core/fat12cce_back.sv @@
// ----------------------------------------------------------------------------
// FAT12 cluster chain engine back
// Holds the allocation table and executes lookup, link, allocate and load.
// ----------------------------------------------------------------------------
module fat12cce_back #(
    parameter int ENTRIES = fat12cce_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  fat12cce_pkg::t_cmd         i_cmd,
    output logic                       o_cmd_take,
    input  logic [$clog2(ENTRIES):0]   i_limit,
    input  logic                       i_rsp_full,
    output logic                       o_rsp_push,
    output fat12cce_pkg::t_rsp         o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = AW + 1;
    localparam int CW = fat12cce_pkg::CLU_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_LINK = 5'b01000,
        S_MARK = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    fat12cce_pkg::t_req r_req,   n_req;
    logic [LW-1:0]      r_scan,  n_scan;
    logic               r_chk_vld, n_chk_vld;
    logic [AW-1:0]      r_chk_addr, n_chk_addr;

    logic [CW-1:0]      r_mem [ENTRIES];
    logic [CW-1:0]      r_rdata;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic [CW-1:0]      mem_wdata;
    logic               mem_we;

    logic               is_end;
    logic               is_free;

    // high indexes count as chain ends without looking at the entry
    assign is_end  = (r_req.cluster >= fat12cce_pkg::END_MARK) ||
                     (r_rdata >= fat12cce_pkg::END_MARK);
    assign is_free = (r_rdata == fat12cce_pkg::FREE_MARK);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_scan     = r_scan;
        n_chk_vld  = r_chk_vld;
        n_chk_addr = r_chk_addr;
        o_cmd_take = 1'b0;
        o_rsp_push = 1'b0;
        o_rsp      = '{status: fat12cce_pkg::ST_OK, result_cluster: '0};
        mem_we     = 1'b0;
        mem_waddr  = r_req.cluster[AW-1:0];
        mem_wdata  = r_req.value;
        mem_raddr  = i_cmd.req.cluster[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                // start only with a result slot free, so the push never stalls
                if (i_cmd_valid && !i_rsp_full) begin
                    o_cmd_take = 1'b1;
                    n_req      = i_cmd.req;
                    n_scan     = '0;
                    n_chk_vld  = 1'b0;
                    if (i_cmd.oor) begin
                        o_rsp_push   = 1'b1;
                        o_rsp.status = fat12cce_pkg::ST_RANGE;
                    end else begin
                        unique case (i_cmd.req.op)
                            fat12cce_pkg::OP_LOAD: begin
                                mem_we     = 1'b1;
                                mem_waddr  = i_cmd.req.cluster[AW-1:0];
                                mem_wdata  = i_cmd.req.value;
                                o_rsp_push = 1'b1;
                            end
                            fat12cce_pkg::OP_ALLOC: begin
                                n_state = (i_cmd.req.cluster == '0) ? S_SCAN : S_EXEC;
                            end
                            fat12cce_pkg::OP_LOOKUP,
                            fat12cce_pkg::OP_LINK: begin
                                n_state = S_EXEC;
                            end
                        endcase
                    end
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_req.op)
                    fat12cce_pkg::OP_LOOKUP: begin
                        o_rsp_push = 1'b1;
                        o_rsp.result_cluster =
                            (r_rdata >= fat12cce_pkg::END_MARK) ? '0 : r_rdata;
                    end
                    fat12cce_pkg::OP_LINK: begin
                        o_rsp_push = 1'b1;
                        if (is_end || is_free) begin
                            mem_we = 1'b1;
                        end else begin
                            o_rsp.status = fat12cce_pkg::ST_REFUSED;
                        end
                    end
                    fat12cce_pkg::OP_ALLOC: begin
                        if (is_end) begin
                            n_state = S_SCAN;
                        end else begin
                            o_rsp_push   = 1'b1;
                            o_rsp.status = fat12cce_pkg::ST_REFUSED;
                        end
                    end
                    fat12cce_pkg::OP_LOAD: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                // one read issued per cycle, checked in the following cycle
                mem_raddr = r_scan[AW-1:0];
                if (r_chk_vld && is_free) begin
                    n_state = S_LINK;
                end else if (!r_chk_vld && (r_scan >= i_limit)) begin
                    o_rsp_push   = 1'b1;
                    o_rsp.status = fat12cce_pkg::ST_NOFREE;
                    n_state      = S_IDLE;
                end else if (r_scan < i_limit) begin
                    n_scan     = r_scan + LW'(1);
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_scan[AW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            S_LINK: begin
                if (r_req.cluster != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = CW'(r_chk_addr);
                end
                n_state = S_MARK;
            end
            S_MARK: begin
                mem_we     = 1'b1;
                mem_waddr  = r_chk_addr;
                mem_wdata  = fat12cce_pkg::END_MARK;
                o_rsp_push = 1'b1;
                o_rsp.result_cluster = CW'(r_chk_addr);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_scan     <= n_scan;
        r_chk_addr <= n_chk_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule
